@@ rtl/core/mlfd_pkg.sv @@
// Package for the multichannel length-prefixed frame deframer.
// Holds result and kind codes, register indexes, reset values and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package mlfd_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int MASK_W           = 4;
  localparam int POS_W            = 9;
  localparam int TIMER_W          = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;

  localparam logic [POS_W-1:0] FRAME_OVERHEAD = 9'd5;
  localparam logic [POS_W-1:0] LENGTH_OFFSET  = 9'd2;

  localparam logic [7:0]         HEADER_RST  = 8'hFE;
  localparam logic [7:0]         TRAILER_RST = 8'hFF;
  localparam logic [TIMER_W-1:0] TIMEOUT_RST = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [1:0]        chan;
    logic [7:0]        data;
    logic              first;
    logic              last;
    logic              good;
    logic [MASK_W-1:0] mask;
  } result_t;

endpackage

@@ rtl/core/multichannel_length_frame_deframer_top.sv @@
// Multichannel length-prefixed frame deframer, top level.
// Depends on mlfd_pkg.
//
// Usage: each input word is a data byte tagged with a channel, or a timer tick.
// Every channel hunts for the header byte, reads the payload length at frame
// offset 2 and forwards the length+5 frame bytes with first/last marks; the
// last byte carries a good flag when it equals the trailer value. In-frame
// bytes reload the channel's idle timer; ticks count timers down and a tick
// that expires timers gives one timeout word with a channel mask.
// Channels: in_* (valid/stall), out_* (valid/stall), cfg_* (valid/ready,
// always ready; write only while idle).
// Throughput: one input word per cycle while in_stall is low; per-channel
// state is updated in the accept cycle and the result lands in the output
// register, or in the skid entry while that register is held. A two-entry
// output stage (output register plus skid) lets input flow while a result
// waits; in_stall rises only when both entries are full. Dropped bytes and
// ticks with nothing expiring give no result. Reset: all channels hunting,
// timers zero, registers at their reset values, output empty.
`timescale 1ns / 1ps

module multichannel_length_frame_deframer_top
  import mlfd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [1:0]            in_channel,
  input  logic [7:0]            in_data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_result_kind,
  output logic [1:0]            out_channel,
  output logic [7:0]            out_byte,
  output logic                  out_frame_first,
  output logic                  out_frame_last,
  output logic                  out_frame_good,
  output logic [MASK_W-1:0]     out_timed_out_mask,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [7:0]         header_r, trailer_r;
  logic [TIMER_W-1:0] timeout_r;

  logic               in_frame_r  [NUM_CHANNELS];
  logic [POS_W-1:0]   pos_r       [NUM_CHANNELS];
  logic [POS_W-1:0]   total_r     [NUM_CHANNELS];
  logic [TIMER_W-1:0] timer_r     [NUM_CHANNELS];
  logic               in_frame_nxt[NUM_CHANNELS];
  logic [POS_W-1:0]   pos_nxt     [NUM_CHANNELS];
  logic [POS_W-1:0]   total_nxt   [NUM_CHANNELS];
  logic [TIMER_W-1:0] timer_nxt   [NUM_CHANNELS];

  logic [NUM_CHANNELS-1:0] expire;
  logic [MASK_W+NUM_CHANNELS-1:0] expire_ext;
  logic    accept, emit, b_first, b_last, b_good;
  result_t res;
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= HEADER_RST;
      trailer_r <= TRAILER_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER:  header_r  <= cfg_data[7:0];
        REG_TRAILER: trailer_r <= cfg_data[7:0];
        REG_TIMEOUT: timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    expire  = '0;
    emit    = 1'b0;
    b_first = 1'b0;
    b_last  = 1'b0;
    b_good  = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin : g_ch
      logic             hit;
      logic [POS_W:0]   pos_inc;
      logic [POS_W-1:0] tot_eff;
      hit     = (in_action == ACT_BYTE) && ({3'b000, in_channel} == 5'(c));
      pos_inc = {1'b0, pos_r[c]} + {{POS_W{1'b0}}, 1'b1};
      tot_eff = (pos_r[c] == LENGTH_OFFSET) ? ({1'b0, in_data_byte} + FRAME_OVERHEAD)
                                            : total_r[c];
      in_frame_nxt[c] = in_frame_r[c];
      pos_nxt[c]      = pos_r[c];
      total_nxt[c]    = total_r[c];
      timer_nxt[c]    = timer_r[c];
      if (in_action == ACT_TICK) begin
        if (in_frame_r[c]) begin
          if (timer_r[c] <= TIMER_W'(1)) begin
            expire[c]       = 1'b1;
            in_frame_nxt[c] = 1'b0;
            pos_nxt[c]      = '0;
            total_nxt[c]    = '0;
            timer_nxt[c]    = '0;
          end else begin
            timer_nxt[c] = timer_r[c] - TIMER_W'(1);
          end
        end
      end else if (hit) begin
        if (!in_frame_r[c]) begin
          if (in_data_byte == header_r) begin
            emit            = 1'b1;
            b_first         = 1'b1;
            in_frame_nxt[c] = 1'b1;
            pos_nxt[c]      = POS_W'(1);
            total_nxt[c]    = '0;
            timer_nxt[c]    = timeout_r;
          end
        end else begin
          emit         = 1'b1;
          timer_nxt[c] = timeout_r;
          total_nxt[c] = tot_eff;
          if ((tot_eff != '0) && (pos_inc >= {1'b0, tot_eff})) begin
            b_last          = 1'b1;
            b_good          = (in_data_byte == trailer_r);
            in_frame_nxt[c] = 1'b0;
            pos_nxt[c]      = '0;
            total_nxt[c]    = '0;
            timer_nxt[c]    = '0;
          end else begin
            pos_nxt[c] = pos_inc[POS_W-1:0];
          end
        end
      end
    end
  end

  assign expire_ext = {{MASK_W{1'b0}}, expire};

  always_comb begin
    res = '0;
    if (in_action == ACT_TICK) begin
      res.kind = KIND_TIMEOUT;
      res.mask = expire_ext[MASK_W-1:0];
    end else begin
      res.kind  = KIND_BYTE;
      res.chan  = in_channel;
      res.data  = in_data_byte;
      res.first = b_first;
      res.last  = b_last;
      res.good  = b_good;
    end
  end

  logic res_valid;
  assign res_valid = accept && (emit || (in_action == ACT_TICK && expire_ext[MASK_W-1:0] != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        in_frame_r[c] <= 1'b0;
        pos_r[c]      <= '0;
        total_r[c]    <= '0;
        timer_r[c]    <= '0;
      end
    end else if (accept) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        in_frame_r[c] <= in_frame_nxt[c];
        pos_r[c]      <= pos_nxt[c];
        total_r[c]    <= total_nxt[c];
        timer_r[c]    <= timer_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_r.kind;
  assign out_channel        = out_r.chan;
  assign out_byte           = out_r.data;
  assign out_frame_first    = out_r.first;
  assign out_frame_last     = out_r.last;
  assign out_frame_good     = out_r.good;
  assign out_timed_out_mask = out_r.mask;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_take) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry not moved to output");

  a_timeout_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_TIMEOUT) |-> (out_r.mask != '0 && !out_r.first
      && !out_r.last && !out_r.good))
    else $error("malformed timeout report");

  a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_BYTE) |-> (out_r.mask == '0
      && (!out_r.good || out_r.last) && !(out_r.first && out_r.last)))
    else $error("malformed frame byte result");

endmodule
